@@ rtl/core/ash_pkg.sv @@
`timescale 1ns / 1ps

package ash_pkg;

  typedef enum logic [1:0] {
    ST_UNDEF = 2'd0,
    ST_CLEAR = 2'd1,
    ST_WARN  = 2'd2,
    ST_CRIT  = 2'd3
  } status_t;

  localparam logic [1:0] LVL_CLEAR  = 2'd1;
  localparam logic [1:0] LVL_RAISED = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_UP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_DOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MULT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PER = 3'd4;

  typedef struct packed {
    logic [15:0] delay_up_secs;
    logic [15:0] delay_down_secs;
    logic [15:0] delay_max_secs;
    logic [15:0] delay_multiplier_q8;
    logic [15:0] update_period_secs;
  } cfg_t;

  typedef struct packed {
    logic        changed;
    status_t     to_status;
    status_t     from_status;
    logic [31:0] event_number;
    logic [15:0] delay_applied;
    logic [31:0] notify_after;
    logic [31:0] held_secs;
    logic [31:0] next_due;
  } res_t;

endpackage

@@ rtl/core/ash_cfg.sv @@
`timescale 1ns / 1ps

module ash_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ash_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ash_pkg::CFG_DATA_W-1:0] cfg_data,
  output ash_pkg::cfg_t                  cfg
);
  import ash_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY_UP:   cfg_nxt.delay_up_secs       = cfg_data;
        REG_DELAY_DOWN: cfg_nxt.delay_down_secs     = cfg_data;
        REG_DELAY_MAX:  cfg_nxt.delay_max_secs      = cfg_data;
        REG_DELAY_MULT: cfg_nxt.delay_multiplier_q8 = cfg_data;
        REG_UPDATE_PER: cfg_nxt.update_period_secs  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_up_secs       <= 16'd0;
      cfg_r.delay_down_secs     <= 16'd0;
      cfg_r.delay_max_secs      <= 16'hFFFF;
      cfg_r.delay_multiplier_q8 <= 16'd256;
      cfg_r.update_period_secs  <= 16'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/ash_eval.sv @@
`timescale 1ns / 1ps

module ash_eval (
  input  logic          clk,
  input  logic          rst_n,
  input  ash_pkg::cfg_t cfg,
  input  logic          fire,
  input  logic [31:0]   now_secs,
  input  logic [1:0]    warning_level,
  input  logic [1:0]    critical_level,
  output ash_pkg::res_t res
);
  import ash_pkg::*;

  status_t     status_r, status_nxt;
  logic [15:0] up_delay_r, up_delay_nxt;
  logic [15:0] down_delay_r, down_delay_nxt;
  logic [31:0] window_end_r, window_end_nxt;
  logic [31:0] last_change_r, last_change_nxt;
  logic [31:0] event_cnt_r, event_cnt_nxt;

  status_t     st;
  logic        chg;
  logic [15:0] delay;
  logic [31:0] notify;

  // (d * mult) >> 8, saturated to 16 bits, then clamped to the ceiling
  function automatic logic [15:0] grow_delay(input logic [15:0] d,
                                             input logic [15:0] mult,
                                             input logic [15:0] dmax);
    logic [31:0] prod;
    logic [23:0] shifted;
    logic [15:0] sat;
    prod    = d * mult;
    shifted = prod[31:8];
    sat     = (shifted[23:16] != 8'd0) ? 16'hFFFF : shifted[15:0];
    return (sat > dmax) ? dmax : sat;
  endfunction

  always_comb begin
    st = ST_UNDEF;
    case (warning_level)
      LVL_CLEAR:  st = ST_CLEAR;
      LVL_RAISED: st = ST_WARN;
      default:    st = ST_UNDEF;
    endcase
    case (critical_level)
      LVL_CLEAR:  if (st == ST_UNDEF) st = ST_CLEAR;
      LVL_RAISED: st = ST_CRIT;
      default: ;
    endcase
  end

  assign chg = (st != status_r);

  always_comb begin
    up_delay_nxt    = up_delay_r;
    down_delay_nxt  = down_delay_r;
    window_end_nxt  = window_end_r;
    last_change_nxt = last_change_r;
    event_cnt_nxt   = event_cnt_r;
    status_nxt      = status_r;
    delay           = 16'd0;
    notify          = 32'd0;
    if (chg) begin
      if (now_secs > window_end_r) begin
        up_delay_nxt   = cfg.delay_up_secs;
        down_delay_nxt = cfg.delay_down_secs;
      end else begin
        up_delay_nxt   = grow_delay(up_delay_r, cfg.delay_multiplier_q8, cfg.delay_max_secs);
        down_delay_nxt = grow_delay(down_delay_r, cfg.delay_multiplier_q8,
                                    cfg.delay_max_secs);
      end
      delay           = (st > status_r) ? up_delay_nxt : down_delay_nxt;
      notify          = now_secs + {16'd0, delay};
      window_end_nxt  = notify;
      last_change_nxt = now_secs;
      event_cnt_nxt   = event_cnt_r + 32'd1;
      status_nxt      = st;
    end
  end

  always_comb begin
    res.changed       = chg;
    res.to_status     = chg ? st : status_r;
    res.from_status   = status_r;
    res.event_number  = chg ? event_cnt_r : 32'd0;
    res.delay_applied = delay;
    res.notify_after  = notify;
    res.held_secs     = now_secs - last_change_r;
    res.next_due      = now_secs + {16'd0, cfg.update_period_secs};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r      <= ST_UNDEF;
      up_delay_r    <= 16'd0;
      down_delay_r  <= 16'd0;
      window_end_r  <= 32'd0;
      last_change_r <= 32'd0;
      event_cnt_r   <= 32'd0;
    end else if (fire) begin
      status_r      <= status_nxt;
      up_delay_r    <= up_delay_nxt;
      down_delay_r  <= down_delay_nxt;
      window_end_r  <= window_end_nxt;
      last_change_r <= last_change_nxt;
      event_cnt_r   <= event_cnt_nxt;
    end
  end

endmodule

@@ rtl/core/alarm_status_hysteresis_top.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   now_secs, warning_level, critical_level
// out_      output     out_valid / out_ready changed, statuses, event, delay, times
// cfg_      input      cfg_we                cfg_index, cfg_data
//
// one item per cycle sustained while out_ready keeps the result register moving; an accepted item reaches out_valid via
// the input register, then evaluation into the result register
// alarm state advances when an item moves from the input register to the result register
// rst_n is synchronous; it clears valids, alarm state and loads register defaults
// a stalled result holds in the result register while one more item waits in the input register

module alarm_status_hysteresis_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_now_secs,
  input  logic [1:0]                     in_warning_level,
  input  logic [1:0]                     in_critical_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_changed,
  output logic [1:0]                     out_to_status,
  output logic [1:0]                     out_from_status,
  output logic [31:0]                    out_event_number,
  output logic [15:0]                    out_delay_applied,
  output logic [31:0]                    out_notify_after,
  output logic [31:0]                    out_held_secs,
  output logic [31:0]                    out_next_due,
  input  logic                           cfg_we,
  input  logic [ash_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ash_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ash_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;

  logic        in_valid_r;
  logic [31:0] now_r;
  logic [1:0]  warn_r;
  logic [1:0]  crit_r;
  logic        out_valid_r;
  logic        advance;
  logic        fire;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  ash_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ash_eval u_eval (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .fire           (fire),
    .now_secs       (now_r),
    .warning_level  (warn_r),
    .critical_level (crit_r),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r  <= in_now_secs;
      warn_r <= in_warning_level;
      crit_r <= in_critical_level;
    end
    if (fire) res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_changed       = res_r.changed;
  assign out_to_status     = res_r.to_status;
  assign out_from_status   = res_r.from_status;
  assign out_event_number  = res_r.event_number;
  assign out_delay_applied = res_r.delay_applied;
  assign out_notify_after  = res_r.notify_after;
  assign out_held_secs     = res_r.held_secs;
  assign out_next_due      = res_r.next_due;

endmodule
